### design/cau_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the complex arithmetic unit
// no dependencies

package cau_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // control that travels with each transaction down the pipe
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       dz;
        logic       ovf_r;
        logic       ovf_i;
        logic       neg_r;
        logic       neg_i;
    } t_ctrl;

endpackage

### design/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// complex add, subtract, multiply and divide in signed fixed point
// depends on cau_pkg, cau_front, cau_div_step
//
// usage:
//   input channel: i_valid with operands and operation, o_stall back to the
//   sender; a transaction is taken when i_valid is high and o_stall is low.
//   output channel: o_valid with result parts and status, i_stall from the
//   receiver; a transaction is delivered when o_valid is high and i_stall low.
//   pipeline: four front stages, one quotient bit per stage over DATA_WIDTH + 1
//   divider stages, and the output register, passed by every operation.
//   throughput: one transaction per cycle while no stall holds the pipe; every
//   operation takes the same path so results leave in the order they came.
//   stall: the whole pipe holds while a result sits unaccepted under i_stall,
//   and o_stall rises in that case; nothing is dropped or repeated.
//   reset: synchronous on i_rst_n low; all valid bits clear, pipe empty.
//   divide by zero gives zero parts and status 2, saturation status 1.

module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_a_real,
    input  logic signed [DATA_WIDTH-1:0] i_a_imag,
    input  logic signed [DATA_WIDTH-1:0] i_b_real,
    input  logic signed [DATA_WIDTH-1:0] i_b_imag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_result_real,
    output logic signed [DATA_WIDTH-1:0] o_result_imag,
    output logic [1:0]                   o_status
);
    localparam int W  = DATA_WIDTH;
    localparam int DW = 3 * W + FRAC_BITS + 1;
    localparam int NS = W + 1;

    logic s_en;

    t_ctrl         s_ctrl  [NS+1];
    logic [DW-1:0] s_rem_r [NS+1];
    logic [DW-1:0] s_rem_i [NS+1];
    logic [W:0]    s_q_r   [NS+1];
    logic [W:0]    s_q_i   [NS+1];
    logic [2*W:0]  s_den   [NS+1];

    logic          r_valid;
    logic [W-1:0]  r_res_r, r_res_i, n_res_r, n_res_i;
    logic [1:0]    r_status, n_status;
    logic [DW-1:0] f_mag_r, f_mag_i, f_lim_r, f_lim_i;
    logic          f_sat_r, f_sat_i, f_neg_r, f_neg_i;
    t_ctrl         f_ctrl;

    // pipe advances unless the held result is stalled
    assign s_en    = !(r_valid && i_stall);
    assign o_stall = r_valid && i_stall;

    cau_front #(.W(W), .F(FRAC_BITS), .DW(DW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (i_valid),
        .i_op    (i_operation),
        .i_ar    (i_a_real),
        .i_ai    (i_a_imag),
        .i_br    (i_b_real),
        .i_bi    (i_b_imag),
        .o_ctrl  (s_ctrl[0]),
        .o_rem_r (s_rem_r[0]),
        .o_rem_i (s_rem_i[0]),
        .o_den   (s_den[0])
    );

    assign s_q_r[0] = '0;
    assign s_q_i[0] = '0;

    // divider stages, most significant quotient bit first
    for (genvar j = 0; j < NS; j++) begin : g_div
        cau_div_step #(.W(W), .DW(DW), .K(W - j)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_ctrl  (s_ctrl[j]),
            .i_rem_r (s_rem_r[j]),
            .i_rem_i (s_rem_i[j]),
            .i_q_r   (s_q_r[j]),
            .i_q_i   (s_q_i[j]),
            .i_den   (s_den[j]),
            .o_ctrl  (s_ctrl[j+1]),
            .o_rem_r (s_rem_r[j+1]),
            .o_rem_i (s_rem_i[j+1]),
            .o_q_r   (s_q_r[j+1]),
            .o_q_i   (s_q_i[j+1]),
            .o_den   (s_den[j+1])
        );
    end

    // pick magnitude, saturate, apply sign
    always_comb begin
        f_ctrl = s_ctrl[NS];
        if (f_ctrl.op == OP_DIV) begin
            f_mag_r = f_ctrl.ovf_r ? {DW{1'b1}} : DW'(s_q_r[NS]);
            f_mag_i = f_ctrl.ovf_i ? {DW{1'b1}} : DW'(s_q_i[NS]);
        end else begin
            f_mag_r = s_rem_r[NS];
            f_mag_i = s_rem_i[NS];
        end
        f_neg_r = f_ctrl.neg_r && (f_mag_r != '0);
        f_neg_i = f_ctrl.neg_i && (f_mag_i != '0);
        f_lim_r = f_neg_r ? (DW'(1) << (W - 1)) : ((DW'(1) << (W - 1)) - DW'(1));
        f_lim_i = f_neg_i ? (DW'(1) << (W - 1)) : ((DW'(1) << (W - 1)) - DW'(1));
        f_sat_r = (f_mag_r > f_lim_r);
        f_sat_i = (f_mag_i > f_lim_i);
        if (f_sat_r) f_mag_r = f_lim_r;
        if (f_sat_i) f_mag_i = f_lim_i;
        n_res_r = f_neg_r ? -f_mag_r[W-1:0] : f_mag_r[W-1:0];
        n_res_i = f_neg_i ? -f_mag_i[W-1:0] : f_mag_i[W-1:0];
        n_status = (f_sat_r || f_sat_i) ? ST_SAT : ST_OK;
        if (f_ctrl.op == OP_DIV && f_ctrl.dz) begin
            n_res_r  = '0;
            n_res_i  = '0;
            n_status = ST_DZ;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_en) begin
            r_valid <= f_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_res_r  <= n_res_r;
            r_res_i  <= n_res_i;
            r_status <= n_status;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_real = r_res_r;
    assign o_result_imag = r_res_i;
    assign o_status      = r_status;

    // divide by zero always reports zero parts
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DZ) |-> (o_result_real == '0 && o_result_imag == '0))
        else $error("divide by zero result not zero");

    // status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_SAT || o_status == ST_DZ))
        else $error("undefined status code");

    // backpressure only while a result is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised without held result");

endmodule

### design/cau_front.sv
`timescale 1ns / 1ps
// front end: operand register, products, sums, divider setup (four stages)
// depends on cau_pkg

module cau_front import cau_pkg::*; #(
    parameter int W  = 16,
    parameter int F  = 8,
    parameter int DW = 3 * W + F + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [1:0]          i_op,
    input  logic signed [W-1:0] i_ar,
    input  logic signed [W-1:0] i_ai,
    input  logic signed [W-1:0] i_br,
    input  logic signed [W-1:0] i_bi,
    output t_ctrl               o_ctrl,
    output logic [DW-1:0]       o_rem_r,
    output logic [DW-1:0]       o_rem_i,
    output logic [2*W:0]        o_den
);
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int MG = 2 * W + 1;

    t_ctrl r_a_ctrl, r_b_ctrl, r_c_ctrl, r_d_ctrl;
    t_ctrl n_c_ctrl, n_d_ctrl;

    logic signed [W-1:0]  r_ar, r_ai, r_br, r_bi;
    logic signed [PW-1:0] r_prr, r_pii, r_pri, r_pir, r_pbb, r_pdd;
    logic signed [SW-1:0] r_sr_as, r_si_as, n_sr_as, n_si_as;
    logic [MG-1:0]        r_mag_r, r_mag_i, r_den, n_mag_r, n_mag_i, n_den;
    logic signed [SW-1:0] c_sr, c_si, c_abs_r, c_abs_i;
    logic [DW-1:0]        r_rem_r, r_rem_i, n_rem_r, n_rem_i, d_lim;
    logic [MG-1:0]        r_den_d;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl.valid <= 1'b0;
            r_b_ctrl.valid <= 1'b0;
            r_c_ctrl.valid <= 1'b0;
            r_d_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_a_ctrl.valid <= i_valid;
            r_b_ctrl.valid <= r_a_ctrl.valid;
            r_c_ctrl.valid <= r_b_ctrl.valid;
            r_d_ctrl.valid <= r_c_ctrl.valid;
        end
    end

    // stage b sums for add and subtract
    always_comb begin
        if (r_a_ctrl.op == OP_SUB) begin
            n_sr_as = SW'(r_ar) - SW'(r_br);
            n_si_as = SW'(r_ai) - SW'(r_bi);
        end else begin
            n_sr_as = SW'(r_ar) + SW'(r_br);
            n_si_as = SW'(r_ai) + SW'(r_bi);
        end
    end

    // stage c: exact signed parts, then magnitudes
    always_comb begin
        n_c_ctrl = r_b_ctrl;
        case (r_b_ctrl.op)
            OP_MUL: begin
                c_sr = SW'(r_prr) - SW'(r_pii);
                c_si = SW'(r_pri) + SW'(r_pir);
            end
            OP_DIV: begin
                c_sr = SW'(r_prr) + SW'(r_pii);
                c_si = SW'(r_pir) - SW'(r_pri);
            end
            default: begin
                c_sr = r_sr_as;
                c_si = r_si_as;
            end
        endcase
        c_abs_r = c_sr[SW-1] ? -c_sr : c_sr;
        c_abs_i = c_si[SW-1] ? -c_si : c_si;
        n_c_ctrl.neg_r = c_sr[SW-1];
        n_c_ctrl.neg_i = c_si[SW-1];
        n_mag_r = c_abs_r[MG-1:0];
        n_mag_i = c_abs_i[MG-1:0];
        if (r_b_ctrl.op == OP_MUL) begin
            n_mag_r = n_mag_r >> F;
            n_mag_i = n_mag_i >> F;
        end
        n_den = MG'($unsigned(r_pbb)) + MG'($unsigned(r_pdd));
    end

    // stage d: scale dividend, flag quotient overflow and zero divisor
    always_comb begin
        n_d_ctrl    = r_c_ctrl;
        d_lim       = DW'(r_den) << (W + 1);
        n_d_ctrl.dz = (r_den == '0);
        if (r_c_ctrl.op == OP_DIV) begin
            n_rem_r = DW'(r_mag_r) << F;
            n_rem_i = DW'(r_mag_i) << F;
        end else begin
            n_rem_r = DW'(r_mag_r);
            n_rem_i = DW'(r_mag_i);
        end
        n_d_ctrl.ovf_r = (n_rem_r >= d_lim);
        n_d_ctrl.ovf_i = (n_rem_i >= d_lim);
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctrl.op    <= i_op;
            r_a_ctrl.dz    <= 1'b0;
            r_a_ctrl.ovf_r <= 1'b0;
            r_a_ctrl.ovf_i <= 1'b0;
            r_a_ctrl.neg_r <= 1'b0;
            r_a_ctrl.neg_i <= 1'b0;
            r_ar <= i_ar;
            r_ai <= i_ai;
            r_br <= i_br;
            r_bi <= i_bi;
            {r_b_ctrl.op, r_b_ctrl.dz, r_b_ctrl.ovf_r, r_b_ctrl.ovf_i,
             r_b_ctrl.neg_r, r_b_ctrl.neg_i} <=
            {r_a_ctrl.op, r_a_ctrl.dz, r_a_ctrl.ovf_r, r_a_ctrl.ovf_i,
             r_a_ctrl.neg_r, r_a_ctrl.neg_i};
            r_prr   <= r_ar * r_br;
            r_pii   <= r_ai * r_bi;
            r_pri   <= r_ar * r_bi;
            r_pir   <= r_ai * r_br;
            r_pbb   <= r_br * r_br;
            r_pdd   <= r_bi * r_bi;
            r_sr_as <= n_sr_as;
            r_si_as <= n_si_as;
            {r_c_ctrl.op, r_c_ctrl.dz, r_c_ctrl.ovf_r, r_c_ctrl.ovf_i,
             r_c_ctrl.neg_r, r_c_ctrl.neg_i} <=
            {n_c_ctrl.op, n_c_ctrl.dz, n_c_ctrl.ovf_r, n_c_ctrl.ovf_i,
             n_c_ctrl.neg_r, n_c_ctrl.neg_i};
            r_mag_r <= n_mag_r;
            r_mag_i <= n_mag_i;
            r_den   <= n_den;
            {r_d_ctrl.op, r_d_ctrl.dz, r_d_ctrl.ovf_r, r_d_ctrl.ovf_i,
             r_d_ctrl.neg_r, r_d_ctrl.neg_i} <=
            {n_d_ctrl.op, n_d_ctrl.dz, n_d_ctrl.ovf_r, n_d_ctrl.ovf_i,
             n_d_ctrl.neg_r, n_d_ctrl.neg_i};
            r_rem_r <= n_rem_r;
            r_rem_i <= n_rem_i;
            r_den_d <= r_den;
        end
    end

    assign o_ctrl  = r_d_ctrl;
    assign o_rem_r = r_rem_r;
    assign o_rem_i = r_rem_i;
    assign o_den   = r_den_d;

endmodule

### design/cau_div_step.sv
`timescale 1ns / 1ps
// one restoring division stage for divide operations: decides quotient bit K for both parts
// depends on cau_pkg

module cau_div_step import cau_pkg::*; #(
    parameter int W  = 16,
    parameter int DW = 57,
    parameter int K  = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctrl         i_ctrl,
    input  logic [DW-1:0] i_rem_r,
    input  logic [DW-1:0] i_rem_i,
    input  logic [W:0]    i_q_r,
    input  logic [W:0]    i_q_i,
    input  logic [2*W:0]  i_den,
    output t_ctrl         o_ctrl,
    output logic [DW-1:0] o_rem_r,
    output logic [DW-1:0] o_rem_i,
    output logic [W:0]    o_q_r,
    output logic [W:0]    o_q_i,
    output logic [2*W:0]  o_den
);
    t_ctrl         r_ctrl;
    logic [DW-1:0] r_rem_r, r_rem_i, n_rem_r, n_rem_i, s_den;
    logic [W:0]    r_q_r, r_q_i, n_q_r, n_q_i;
    logic [2*W:0]  r_den;
    logic          s_div;

    // trial subtract of the shifted divisor
    always_comb begin
        s_den   = DW'(i_den) << K;
        s_div   = (i_ctrl.op == OP_DIV);
        n_rem_r = i_rem_r;
        n_rem_i = i_rem_i;
        n_q_r   = i_q_r;
        n_q_i   = i_q_i;
        if (s_div && (i_rem_r >= s_den)) begin
            n_rem_r  = i_rem_r - s_den;
            n_q_r[K] = 1'b1;
        end
        if (s_div && (i_rem_i >= s_den)) begin
            n_rem_i  = i_rem_i - s_den;
            n_q_i[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl.valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_ctrl.op, r_ctrl.dz, r_ctrl.ovf_r, r_ctrl.ovf_i,
             r_ctrl.neg_r, r_ctrl.neg_i} <=
            {i_ctrl.op, i_ctrl.dz, i_ctrl.ovf_r, i_ctrl.ovf_i,
             i_ctrl.neg_r, i_ctrl.neg_i};
            r_rem_r <= n_rem_r;
            r_rem_i <= n_rem_i;
            r_q_r   <= n_q_r;
            r_q_i   <= n_q_i;
            r_den   <= i_den;
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_rem_r = r_rem_r;
    assign o_rem_i = r_rem_i;
    assign o_q_r   = r_q_r;
    assign o_q_i   = r_q_i;
    assign o_den   = r_den;

endmodule

### bench/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// self-checking bench for complex_arithmetic_unit: random and corner operand pairs
// for add, subtract, multiply and divide, checked in order against an exact predictor
// depends on cau_pkg and complex_arithmetic_unit

module tb_complex_arithmetic_unit import cau_pkg::*;;

    localparam int DW = 16;
    localparam int FB = 8;
    localparam int N_RANDOM = 1800;
    localparam longint MAX_CYCLES = 400000;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
    } t_operands;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic [1:0]           st;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_operation = OP_ADD;
    logic signed [DW-1:0] i_a_real = '0, i_a_imag = '0, i_b_real = '0, i_b_imag = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    logic signed [DW-1:0] o_result_real, o_result_imag;
    logic [1:0] o_status;

    t_operands pending_ops[$];
    t_result   expected_results[$];
    bit        stimulus_done = 1'b0;
    int        errors = 0;
    longint    cycle_count = 0;

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_a_real(i_a_real), .i_a_imag(i_a_imag),
        .i_b_real(i_b_real), .i_b_imag(i_b_imag), .o_valid(o_valid),
        .i_stall(i_stall), .o_result_real(o_result_real),
        .o_result_imag(o_result_imag), .o_status(o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // clamp one exact part to the output range, flag saturation
    function automatic logic signed [DW-1:0] clamp_part(input longint v, inout bit sat);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (DW - 1)) - 1;
        lo = -(64'sd1 <<< (DW - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // truncating quotient of num * 2^FB by den, sign applied after
    function automatic longint scaled_quotient(input longint num, input longint den);
        longint mag;
        mag = num < 0 ? -num : num;
        mag = (mag <<< FB) / den;
        return num < 0 ? -mag : mag;
    endfunction

    // exact complex result for one operand set
    function automatic t_result complex_result(input t_operands t);
        t_result r;
        longint ar, ai, br, bi, re, im, den, p;
        bit sat;
        ar = t.ar; ai = t.ai; br = t.br; bi = t.bi;
        sat = 1'b0;
        case (t.op)
            OP_ADD: begin re = ar + br; im = ai + bi; end
            OP_SUB: begin re = ar - br; im = ai - bi; end
            OP_MUL: begin
                p = ar * br - ai * bi;
                re = p < 0 ? -((-p) >>> FB) : p >>> FB;
                p = ar * bi + ai * br;
                im = p < 0 ? -((-p) >>> FB) : p >>> FB;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.re = '0; r.im = '0; r.st = ST_DZ;
                    return r;
                end
                re = scaled_quotient(ar * br + ai * bi, den);
                im = scaled_quotient(ai * br - ar * bi, den);
            end
        endcase
        r.re = clamp_part(re, sat);
        r.im = clamp_part(im, sat);
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    function automatic logic signed [DW-1:0] random_part();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus: corner cases, then random sets
    initial begin
        t_operands t;
        logic signed [DW-1:0] corners[4];
        corners = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0100};
        for (int k = 0; k < 4; k++) begin
            t.op = 2'(k);
            t.ar = corners[0]; t.ai = corners[1]; t.br = corners[1]; t.bi = corners[0];
            pending_ops.push_back(t);
            t.ar = corners[1]; t.ai = corners[1]; t.br = corners[1]; t.bi = corners[1];
            pending_ops.push_back(t);
            t.ar = corners[3]; t.ai = corners[2]; t.br = corners[3]; t.bi = corners[2];
            pending_ops.push_back(t);
            t.ar = corners[0]; t.ai = corners[0]; t.br = corners[0]; t.bi = corners[0];
            pending_ops.push_back(t);
        end
        // divide by zero, and a tiny divisor that overflows
        t.op = OP_DIV; t.ar = 16'sh1234; t.ai = -16'sh0777; t.br = '0; t.bi = '0;
        pending_ops.push_back(t);
        t.br = 16'sh0001; t.bi = '0;
        pending_ops.push_back(t);
        for (int n = 0; n < N_RANDOM; n++) begin
            t.op = 2'($urandom_range(0, 3));
            t.ar = random_part(); t.ai = random_part();
            t.br = random_part(); t.bi = random_part();
            if ($urandom_range(0, 49) == 0) begin
                t.op = OP_DIV; t.br = '0; t.bi = '0;
            end
            pending_ops.push_back(t);
        end
        stimulus_done = 1'b1;
    end

    // driver: one transaction at a time, random gap after each
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_operands t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_stall) begin
            // hold stalled transaction
        end else begin
            if (i_valid) begin
                t = {i_operation, i_a_real, i_a_imag, i_b_real, i_b_imag};
                expected_results.push_back(complex_result(t));
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                t = pending_ops.pop_front();
                i_operation <= t.op;
                i_a_real <= t.ar; i_a_imag <= t.ai;
                i_b_real <= t.br; i_b_imag <= t.bi;
                i_valid <= 1'b1;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each delivered transaction with the oldest prediction
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result re=%0d im=%0d st=%0d", $time,
                             o_result_real, o_result_imag, o_status);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_result_real !== e.re) begin
                        $display("%0t: real expected %0d actual %0d", $time, e.re,
                                 o_result_real);
                        errors++;
                    end
                    if (o_result_imag !== e.im) begin
                        $display("%0t: imag expected %0d actual %0d", $time, e.im,
                                 o_result_imag);
                        errors++;
                    end
                    if (o_status !== e.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st,
                                 o_status);
                        errors++;
                    end
                end
                recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // reset, then wait for the pipe to drain
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && pending_ops.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_results.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
